@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the encoding sniffer RTL.
// Self-contained; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked assertion that is disabled while the active-low reset is asserted.
`define JCS_ASSERT_RST(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
// Clocked assertion that is checked in every cycle, reset included.
`define JCS_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define JCS_ASSERT_RST(label, clk, rstn, prop)
`define JCS_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

@@ hw/rtl/jcs_pkg.sv @@
// Package for the Japanese charset sniffer: types, codes and byte constants.
// Used by every module of the block; depends on nothing.
package jcs_pkg;

    // Default counter width and configuration reset value.
    localparam int COUNT_BITS_DEF = 8;
    localparam logic [7:0] DECIDE_LIMIT_RESET = 8'd20;

    // Detected encoding codes.
    localparam int ENC_W = 3;
    localparam logic [ENC_W-1:0] ENC_EUC     = 3'd0;
    localparam logic [ENC_W-1:0] ENC_JIS     = 3'd1;
    localparam logic [ENC_W-1:0] ENC_SJIS    = 3'd2;
    localparam logic [ENC_W-1:0] ENC_UTF8    = 3'd3;
    localparam logic [ENC_W-1:0] ENC_UTF8BOM = 3'd4;

    // Escape sequence tracking codes.
    localparam logic [1:0] ESC_NONE   = 2'd0;
    localparam logic [1:0] ESC_SEEN   = 2'd1;
    localparam logic [1:0] ESC_DOLLAR = 2'd2;

    // Byte values of interest.
    localparam logic [7:0] CHAR_ESC    = 8'h1b;
    localparam logic [7:0] CHAR_K      = 8'h4b;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_B      = 8'h42;
    localparam logic [7:0] CHAR_AT     = 8'h40;
    localparam logic [7:0] EUC_SS2     = 8'h8e;
    localparam logic [1:0] BOM_LEN     = 2'd3;

    // One input beat.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_data;
        logic       start_of_data;
    } jcs_item_t;

    // Outcome of processing one beat.
    typedef struct packed {
        logic             done;
        logic [ENC_W-1:0] encoding;
    } jcs_result_t;

    // Expected byte of the UTF-8 byte order mark at a given position.
    function automatic logic [7:0] bom_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'hef;
            2'd1:    b = 8'hbb;
            2'd2:    b = 8'hbf;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

@@ hw/rtl/jcs_in_reg.sv @@
// Input register of the charset sniffer: captures one beat from the input channel.
// Depends on jcs_pkg.
module jcs_in_reg
    import jcs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_end_of_data,
    input  logic       s_start_of_data,
    input  logic       advance,
    output logic       item_valid,
    output jcs_item_t  item
);

    logic      valid_reg;
    logic      valid_next;
    jcs_item_t item_reg;

    // The register takes a new beat when empty or when its beat moves on.
    assign s_ready    = !valid_reg || advance;
    assign valid_next = s_valid || (valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= '{data_byte: s_data_byte, end_of_data: s_end_of_data,
                          start_of_data: s_start_of_data};
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ hw/rtl/jcs_core.sv @@
// Detection core: tracker state registers and the single-pass update for one byte.
// Depends on jcs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module jcs_core
    import jcs_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  jcs_item_t   item,
    input  logic [7:0]  decide_limit,
    output jcs_result_t result
);

    localparam int CMP_W = COUNT_BITS + 8;

    logic [1:0]            bom_progress_reg, bom_progress_next;
    logic                  bom_failed_reg, bom_failed_next;
    logic [1:0]            escape_phase_reg, escape_phase_next;
    logic [7:0]            euc_lead_reg, euc_lead_next;
    logic                  sjis_lead_reg, sjis_lead_next;
    logic [1:0]            utf8_pending_reg, utf8_pending_next;
    logic [COUNT_BITS-1:0] euc_good_reg, euc_good_next;
    logic [COUNT_BITS-1:0] euc_bad_reg, euc_bad_next;
    logic [COUNT_BITS-1:0] sjis_good_reg, sjis_good_next;
    logic [COUNT_BITS-1:0] sjis_bad_reg, sjis_bad_next;
    logic [COUNT_BITS-1:0] utf8_good_reg, utf8_good_next;
    logic [COUNT_BITS-1:0] utf8_bad_reg, utf8_bad_next;
    logic                  decided_reg, decided_next;

    logic                  done;
    logic [ENC_W-1:0]      enc;
    logic                  track;
    logic [7:0]            c;
    logic [CMP_W-1:0]      limit_ext;

    // Saturating increment of a counter.
    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v != '1) ? v + 1'b1 : v;
    endfunction

    // Final pick from the sequence counts.
    function automatic logic [ENC_W-1:0] count_rule(
        input logic [COUNT_BITS-1:0] eg, input logic [COUNT_BITS-1:0] eb,
        input logic [COUNT_BITS-1:0] sg, input logic [COUNT_BITS-1:0] sb,
        input logic [COUNT_BITS-1:0] ug, input logic [COUNT_BITS-1:0] ub
    );
        logic [ENC_W-1:0] r;
        if (sg > eg && sg > ug && sb == '0 && ub != '0) begin
            r = ENC_SJIS;
        end else if (eg > sg && eg > ug && eb == '0) begin
            r = ENC_EUC;
        end else begin
            r = ENC_UTF8;
        end
        return r;
    endfunction

    assign c         = item.data_byte;
    assign limit_ext = {{COUNT_BITS{1'b0}}, decide_limit};

    // Single-pass update: clear on start, then either the end-of-stream decision or BOM, escape and tracker logic.
    always_comb begin
        bom_progress_next = item.start_of_data ? 2'd0 : bom_progress_reg;
        bom_failed_next   = item.start_of_data ? 1'b0 : bom_failed_reg;
        escape_phase_next = item.start_of_data ? ESC_NONE : escape_phase_reg;
        euc_lead_next     = item.start_of_data ? 8'd0 : euc_lead_reg;
        sjis_lead_next    = item.start_of_data ? 1'b0 : sjis_lead_reg;
        utf8_pending_next = item.start_of_data ? 2'd0 : utf8_pending_reg;
        euc_good_next     = item.start_of_data ? '0 : euc_good_reg;
        euc_bad_next      = item.start_of_data ? '0 : euc_bad_reg;
        sjis_good_next    = item.start_of_data ? '0 : sjis_good_reg;
        sjis_bad_next     = item.start_of_data ? '0 : sjis_bad_reg;
        utf8_good_next    = item.start_of_data ? '0 : utf8_good_reg;
        utf8_bad_next     = item.start_of_data ? '0 : utf8_bad_reg;
        decided_next      = item.start_of_data ? 1'b0 : decided_reg;
        done  = 1'b0;
        enc   = ENC_UTF8;
        track = 1'b0;

        if (!decided_next) begin
            if (item.end_of_data) begin
                // End of stream: drop any pending escape and decide on the counts.
                escape_phase_next = ESC_NONE;
                enc  = count_rule(euc_good_next, euc_bad_next, sjis_good_next,
                                  sjis_bad_next, utf8_good_next, utf8_bad_next);
                done = 1'b1;
            end else begin
                // Byte order mark at the very start of the stream.
                if (!bom_failed_next) begin
                    if (bom_progress_next != BOM_LEN && c == bom_byte(bom_progress_next)) begin
                        bom_progress_next = bom_progress_next + 2'd1;
                        if (bom_progress_next == BOM_LEN) begin
                            enc  = ENC_UTF8BOM;
                            done = 1'b1;
                        end
                    end else begin
                        bom_failed_next = 1'b1;
                    end
                end

                // Escape sequences that announce ISO-2022-JP.
                if (!done) begin
                    case (escape_phase_next)
                        ESC_SEEN: begin
                            escape_phase_next = ESC_NONE;
                            if (c == CHAR_K) begin
                                enc  = ENC_JIS;
                                done = 1'b1;
                            end else if (c == CHAR_DOLLAR) begin
                                escape_phase_next = ESC_DOLLAR;
                            end else begin
                                track = 1'b1;
                            end
                        end
                        ESC_DOLLAR: begin
                            escape_phase_next = ESC_NONE;
                            if (c == CHAR_B || c == CHAR_AT) begin
                                enc  = ENC_JIS;
                                done = 1'b1;
                            end else begin
                                track = 1'b1;
                            end
                        end
                        default: begin
                            if (c == CHAR_ESC) begin
                                escape_phase_next = ESC_SEEN;
                            end else begin
                                track = 1'b1;
                            end
                        end
                    endcase
                end

                if (track) begin
                    // EUC-JP lead and trail.
                    if (euc_lead_next != 8'd0) begin
                        if ((c >= 8'ha1 && c <= 8'hfe) ||
                            (euc_lead_next == EUC_SS2 && c >= 8'ha0 && c <= 8'hdf)) begin
                            euc_good_next = sat_inc(euc_good_next);
                        end else begin
                            euc_bad_next = sat_inc(euc_bad_next);
                        end
                        euc_lead_next = 8'd0;
                    end else if ((c >= 8'ha1 && c <= 8'hfe) || c == EUC_SS2) begin
                        euc_lead_next = c;
                    end

                    // Shift-JIS lead and trail.
                    if (sjis_lead_next) begin
                        if (c >= 8'h40 && c <= 8'hfc) begin
                            sjis_good_next = sat_inc(sjis_good_next);
                        end else begin
                            sjis_bad_next = sat_inc(sjis_bad_next);
                        end
                        sjis_lead_next = 1'b0;
                    end else if ((c >= 8'h81 && c <= 8'h9f) || (c >= 8'he0 && c <= 8'hfc)) begin
                        sjis_lead_next = 1'b1;
                    end

                    // UTF-8 lead and continuation bytes.
                    if (utf8_pending_next != 2'd0) begin
                        if (c[7:6] == 2'b10) begin
                            utf8_pending_next = utf8_pending_next - 2'd1;
                            if (utf8_pending_next == 2'd0) begin
                                utf8_good_next = sat_inc(utf8_good_next);
                            end
                        end else begin
                            utf8_pending_next = 2'd0;
                            utf8_bad_next     = sat_inc(utf8_bad_next);
                        end
                    end else if (c[7:5] == 3'b110) begin
                        utf8_pending_next = 2'd1;
                    end else if (c[7:4] == 4'he) begin
                        utf8_pending_next = 2'd2;
                    end else if (c[7:4] == 4'hf) begin
                        utf8_pending_next = 2'd3;
                    end else if (c[7]) begin
                        utf8_bad_next = sat_inc(utf8_bad_next);
                    end

                    // Early decision once the EUC-JP or Shift-JIS valid count passes the limit.
                    if ({8'd0, euc_good_next} > limit_ext ||
                        {8'd0, sjis_good_next} > limit_ext) begin
                        enc  = count_rule(euc_good_next, euc_bad_next, sjis_good_next,
                                          sjis_bad_next, utf8_good_next, utf8_bad_next);
                        done = 1'b1;
                    end
                end
            end
            decided_next = done;
        end
    end

    // State registers, updated once per processed beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bom_progress_reg <= 2'd0;
            bom_failed_reg   <= 1'b0;
            escape_phase_reg <= ESC_NONE;
            euc_lead_reg     <= 8'd0;
            sjis_lead_reg    <= 1'b0;
            utf8_pending_reg <= 2'd0;
            euc_good_reg     <= '0;
            euc_bad_reg      <= '0;
            sjis_good_reg    <= '0;
            sjis_bad_reg     <= '0;
            utf8_good_reg    <= '0;
            utf8_bad_reg     <= '0;
            decided_reg      <= 1'b0;
        end else if (step) begin
            bom_progress_reg <= bom_progress_next;
            bom_failed_reg   <= bom_failed_next;
            escape_phase_reg <= escape_phase_next;
            euc_lead_reg     <= euc_lead_next;
            sjis_lead_reg    <= sjis_lead_next;
            utf8_pending_reg <= utf8_pending_next;
            euc_good_reg     <= euc_good_next;
            euc_bad_reg      <= euc_bad_next;
            sjis_good_reg    <= sjis_good_next;
            sjis_bad_reg     <= sjis_bad_next;
            utf8_good_reg    <= utf8_good_next;
            utf8_bad_reg     <= utf8_bad_next;
            decided_reg      <= decided_next;
        end
    end

    assign result = '{done: done, encoding: enc};

    // Once decided, nothing more comes out until a new stream starts.
    `JCS_ASSERT_RST(a_silent_after_decision, aclk, aresetn,
        (decided_reg && !item.start_of_data) |-> !done)
    // A beat that gives a result leaves the decision flag set.
    `JCS_ASSERT_RST(a_decision_latched, aclk, aresetn, (step && done) |=> decided_reg)
    // A complete byte order mark always ends detection.
    `JCS_ASSERT_RST(a_bom_decides, aclk, aresetn, (bom_progress_reg == BOM_LEN) |-> decided_reg)

endmodule

@@ hw/rtl/japanese_charset_sniffer_top.sv @@
// A byte passes the input register and the core update into the result register.
// Throughput: one byte per cycle while no result waits on m_ready; the per-byte
// update is one pass between two registers. The input and result registers let a new
// byte enter while a result waits. Reset (aresetn, synchronous, active low) clears
// all detection state and sets decide_limit to 20; no clearing pass is needed.
// Top level of the charset sniffer; depends on jcs_pkg, jcs_in_reg, jcs_core.
`include "assert_macros.svh"

module japanese_charset_sniffer_top
    import jcs_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [7:0]       cfg_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_data_byte,
    input  logic             s_end_of_data,
    input  logic             s_start_of_data,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [ENC_W-1:0] m_detected_encoding
);

    logic             in_valid;
    jcs_item_t        item;
    jcs_result_t      result;
    logic             advance;
    logic [7:0]       decide_limit_reg;
    logic             m_valid_reg, m_valid_next;
    logic [ENC_W-1:0] enc_reg;

    // Configuration register, always ready.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decide_limit_reg <= DECIDE_LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            decide_limit_reg <= cfg_data;
        end
    end

    jcs_in_reg u_in_reg (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_end_of_data   (s_end_of_data),
        .s_start_of_data (s_start_of_data),
        .advance         (advance),
        .item_valid      (in_valid),
        .item            (item)
    );

    // A held beat is processed when the result register is free or being emptied.
    assign advance = in_valid && (!m_valid_reg || m_ready);

    jcs_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (advance),
        .item         (item),
        .decide_limit (decide_limit_reg),
        .result       (result)
    );

    // Result register.
    assign m_valid_next = (advance && result.done) || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && result.done) begin
            enc_reg <= result.encoding;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_detected_encoding = enc_reg;

    // The input side only stalls while a beat is held.
    `JCS_ASSERT_RST(a_stall_needs_beat, aclk, aresetn, !s_ready |-> in_valid)
    // Every decision reaches the result register.
    `JCS_ASSERT_RST(a_result_loaded, aclk, aresetn, (advance && result.done) |=> m_valid)
    // Only defined encoding codes are presented.
    `JCS_ASSERT_RST(a_enc_range, aclk, aresetn,
        m_valid |-> (m_detected_encoding <= ENC_UTF8BOM))

endmodule
